@@ rtl/wma_pkg.sv @@
`default_nettype none

package wma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_BITS  = 32;

    localparam int IN_PRICE_W  = 32;
    localparam int TS_W        = 63;
    localparam int AVG_W       = 32;
    localparam int WIN_W       = 7;
    localparam int DATA_W      = ((IN_PRICE_W + TS_W + 7) / 8) * 8;

    localparam int APB_DATA_W  = 32;
    localparam int ADDR_W      = 3;

    localparam int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int WSUM_MAX    = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DIV_W       = $clog2(WSUM_MAX + 1);
    localparam int PART_W      = PRICE_BITS + CNT_W;
    localparam int ACC_W       = PRICE_BITS + DIV_W;
    localparam int STEP_W      = $clog2(ACC_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [TS_W-1:0]       ts_t;
    typedef logic [AVG_W-1:0]      avg_t;
    typedef logic [WIN_W-1:0]      win_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DIV_W-1:0]      div_t;
    typedef logic [PART_W-1:0]     part_t;
    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [QPTR_W-1:0]     qptr_t;
    typedef logic [QCNT_W-1:0]     qcnt_t;
    typedef logic [ADDR_W-3:0]     reg_idx_t;

    localparam win_t     WINDOW_RESET      = win_t'(10);
    localparam reg_idx_t REG_WINDOW_LENGTH = reg_idx_t'(0);

    typedef struct packed {
        price_t price;
        ts_t    ts;
        logic   start;
    } q_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MAC,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        back_state_t state;
        cnt_t        fill;
        div_t        divisor;
    } back_status_t;

    // Clamp the register to 1..MAX_WINDOW.
    function automatic cnt_t effective_window(win_t w);
        int unsigned wi;
        wi = 32'(w);
        if (wi == 0) begin
            wi = 1;
        end
        if (wi > MAX_WINDOW) begin
            wi = MAX_WINDOW;
        end
        return cnt_t'(wi);
    endfunction

    function automatic ptr_t ptr_next(ptr_t p);
        return (p == ptr_t'(MAX_WINDOW - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    // Slot k places behind p, modulo the history depth (k never exceeds the depth).
    function automatic ptr_t ptr_back(ptr_t p, cnt_t k);
        int r;
        r = int'(p) - int'(k);
        if (r < 0) begin
            r = r + MAX_WINDOW;
        end
        return ptr_t'(r);
    endfunction

endpackage

`default_nettype wire

@@ rtl/wma_ram.sv @@
`default_nettype none

module wma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/wma_front.sv @@
`default_nettype none

module wma_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [wma_pkg::DATA_W-1:0]   s_tdata,
    input  wire logic                         s_tuser,
    output logic                              q_valid,
    output wma_pkg::q_entry_t                 q_entry,
    input  wire logic                         q_pop
);

    wma_pkg::q_entry_t queue_mem [wma_pkg::QUEUE_DEPTH];
    wma_pkg::qptr_t    wr_ptr_reg;
    wma_pkg::qptr_t    rd_ptr_reg;
    wma_pkg::qcnt_t    count_reg;
    wma_pkg::q_entry_t in_entry;
    logic              push;
    logic              pop;

    // Split the incoming word: price is cast to the stored width, tuser is the series flag.
    always_comb begin
        in_entry.price = wma_pkg::price_t'(s_tdata[wma_pkg::IN_PRICE_W-1:0]);
        in_entry.ts    = s_tdata[wma_pkg::IN_PRICE_W +: wma_pkg::TS_W];
        in_entry.start = s_tuser;
    end

    assign s_tready = (count_reg != wma_pkg::qcnt_t'(wma_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == wma_pkg::qptr_t'(wma_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + wma_pkg::qptr_t'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == wma_pkg::qptr_t'(wma_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + wma_pkg::qptr_t'(1);
            end
            case ({push, pop})
                2'b10: begin
                    count_reg <= count_reg + wma_pkg::qcnt_t'(1);
                end
                2'b01: begin
                    count_reg <= count_reg - wma_pkg::qcnt_t'(1);
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/wma_back.sv @@
`default_nettype none

module wma_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire wma_pkg::win_t          window_length,
    input  wire logic                   q_valid,
    input  wire wma_pkg::q_entry_t      q_entry,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output wma_pkg::avg_t               m_average,
    output wma_pkg::ts_t                m_timestamp,
    output wma_pkg::back_status_t       status
);

    typedef logic [2*wma_pkg::CNT_W:0] wprod_t;
    typedef logic [wma_pkg::DIV_W:0]   trial_t;

    wma_pkg::back_state_t state_reg, state_next;

    wma_pkg::price_t price_reg;
    wma_pkg::ts_t    ts_reg;
    logic            start_reg;
    wma_pkg::cnt_t   n_reg;

    wma_pkg::ptr_t   wptr_reg;
    wma_pkg::cnt_t   fill_reg;
    wma_pkg::price_t first_reg;

    wma_pkg::cnt_t   issue_reg;
    logic            rd_valid_reg;
    logic            rd_mem_reg;
    wma_pkg::part_t  part_reg;
    logic            part_valid_reg;
    wma_pkg::acc_t   acc_reg;

    wma_pkg::div_t   divisor_reg;
    wma_pkg::div_t   rem_reg;
    wma_pkg::acc_t   quo_reg;
    wma_pkg::step_t  step_reg;

    logic            out_valid_reg;
    wma_pkg::avg_t   out_avg_reg;
    wma_pkg::ts_t    out_ts_reg;

    logic            ram_we;
    wma_pkg::ptr_t   wptr_new;
    wma_pkg::ptr_t   ram_raddr;
    wma_pkg::price_t ram_rdata;
    logic            issuing;
    logic            load_out;
    logic            mac_done;
    logic            div_last;
    wprod_t          wprod;
    trial_t          trial;
    logic            fits;
    wma_pkg::div_t   rem_new;

    wma_ram #(
        .WIDTH (wma_pkg::PRICE_BITS),
        .DEPTH (wma_pkg::MAX_WINDOW)
    ) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wptr_new),
        .wdata (price_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign wptr_new  = start_reg ? '0 : wma_pkg::ptr_next(wptr_reg);
    assign ram_raddr = wma_pkg::ptr_back(wptr_reg, issue_reg);
    assign mac_done  = (issue_reg == n_reg) && !rd_valid_reg && !part_valid_reg;
    assign div_last  = (step_reg == wma_pkg::step_t'(wma_pkg::ACC_W - 1));
    assign wprod     = wprod_t'(n_reg) * wprod_t'(n_reg) + wprod_t'(n_reg);

    // One restoring divide step: shift in the next dividend bit, subtract if it fits.
    assign trial   = {rem_reg, quo_reg[wma_pkg::ACC_W-1]};
    assign fits    = (trial >= trial_t'(divisor_reg));
    assign rem_new = fits ? wma_pkg::div_t'(trial - trial_t'(divisor_reg))
                          : wma_pkg::div_t'(trial);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wma_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = wma_pkg::ST_WRITE;
                end
            end
            wma_pkg::ST_WRITE: begin
                state_next = wma_pkg::ST_MAC;
            end
            wma_pkg::ST_MAC: begin
                if (mac_done) begin
                    state_next = wma_pkg::ST_DIV;
                end
            end
            wma_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DONE: begin
                if (load_out) begin
                    state_next = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        ram_we   = 1'b0;
        issuing  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            wma_pkg::ST_IDLE: begin
                q_pop = q_valid;
            end
            wma_pkg::ST_WRITE: begin
                ram_we = 1'b1;
            end
            wma_pkg::ST_MAC: begin
                issuing = (issue_reg < n_reg);
            end
            wma_pkg::ST_DONE: begin
                load_out = !out_valid_reg || m_tready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wma_pkg::ST_IDLE;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            first_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            part_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_valid_reg   <= issuing;
            part_valid_reg <= rd_valid_reg;
            if (state_reg == wma_pkg::ST_WRITE) begin
                wptr_reg <= wptr_new;
                // A series start stands for a history filled with its own price.
                if (start_reg) begin
                    fill_reg  <= wma_pkg::cnt_t'(1);
                    first_reg <= price_reg;
                end else if (fill_reg != wma_pkg::cnt_t'(wma_pkg::MAX_WINDOW)) begin
                    fill_reg <= fill_reg + wma_pkg::cnt_t'(1);
                end
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_mem_reg <= (issue_reg < fill_reg);
        if (q_pop) begin
            price_reg <= q_entry.price;
            ts_reg    <= q_entry.ts;
            start_reg <= q_entry.start;
            n_reg     <= wma_pkg::effective_window(window_length);
        end
        if (state_reg == wma_pkg::ST_WRITE) begin
            issue_reg   <= '0;
            part_reg    <= '0;
            acc_reg     <= '0;
            divisor_reg <= wma_pkg::div_t'(wprod >> 1);
        end
        if (issuing) begin
            issue_reg <= issue_reg + wma_pkg::cnt_t'(1);
        end
        // Running prefix sum newest to oldest; summing the prefixes gives weights N..1.
        if (rd_valid_reg) begin
            part_reg <= part_reg + wma_pkg::part_t'(rd_mem_reg ? ram_rdata : first_reg);
        end
        if (part_valid_reg) begin
            acc_reg <= acc_reg + wma_pkg::acc_t'(part_reg);
        end
        if ((state_reg == wma_pkg::ST_MAC) && mac_done) begin
            quo_reg  <= acc_reg;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == wma_pkg::ST_DIV) begin
            quo_reg  <= {quo_reg[wma_pkg::ACC_W-2:0], fits};
            rem_reg  <= rem_new;
            step_reg <= step_reg + wma_pkg::step_t'(1);
        end
        if (load_out) begin
            out_avg_reg <= wma_pkg::avg_t'(quo_reg);
            out_ts_reg  <= ts_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_average      = out_avg_reg;
    assign m_timestamp    = out_ts_reg;
    assign status.state   = state_reg;
    assign status.fill    = fill_reg;
    assign status.divisor = divisor_reg;

endmodule

`default_nettype wire

@@ rtl/weighted_moving_average.sv @@
// Each accepted s_ word runs through the back-end sequencer: one history memory read per cycle
//   for the weighted sum over N = effective window (1..64) prices, then a 44-step radix-2
//   divider. The back end works on one word at a time.
// A two-word input queue takes s_ words while the back end works; the output register
//   lets the next word start while a result waits on m_tready.
// Reset (aresetn low, synchronous): window_length = 10, history reads as zero, all empty.
`default_nettype none

module weighted_moving_average (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wma_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [wma_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [wma_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [wma_pkg::DATA_W-1:0]       s_tdata,  // price[31:0], timestamp[94:32]
    input  wire logic                             s_tuser,  // series_start
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [wma_pkg::DATA_W-1:0]       m_tdata   // average[31:0], out_timestamp[94:32]
);

    wma_pkg::win_t         window_reg;
    wma_pkg::reg_idx_t     reg_idx;
    logic                  cfg_write;
    logic                  q_valid;
    logic                  q_pop;
    wma_pkg::q_entry_t     q_entry;
    wma_pkg::avg_t         m_average;
    wma_pkg::ts_t          m_timestamp;
    wma_pkg::back_status_t back_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[wma_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= wma_pkg::WINDOW_RESET;
        end else if (cfg_write && (reg_idx == wma_pkg::REG_WINDOW_LENGTH)) begin
            window_reg <= pwdata[wma_pkg::WIN_W-1:0];
        end
    end

    assign prdata = (reg_idx == wma_pkg::REG_WINDOW_LENGTH) ?
                    wma_pkg::APB_DATA_W'(window_reg) : '0;

    wma_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    wma_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window_length (window_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_average     (m_average),
        .m_timestamp   (m_timestamp),
        .status        (back_status)
    );

    assign m_tdata = wma_pkg::DATA_W'({m_timestamp, m_average});

    a_push_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> q_valid)
        else $error("accepted word not visible in queue");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.fill <= wma_pkg::cnt_t'(wma_pkg::MAX_WINDOW))
        else $error("history fill count beyond depth");

    a_divisor_set: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.state == wma_pkg::ST_DIV |-> back_status.divisor != '0)
        else $error("divide with zero window sum");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.state == wma_pkg::ST_DONE && m_tvalid && !m_tready
        |=> back_status.state == wma_pkg::ST_DONE)
        else $error("back end left done while result stalled");

endmodule

`default_nettype wire

@@ tb/tb_weighted_moving_average.sv @@
`default_nettype none

module tb_weighted_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    localparam wma_pkg::reg_idx_t REG_SPARE   = wma_pkg::reg_idx_t'(1);
    localparam int                CYCLE_LIMIT = 800000;
    localparam int                PHASE_WORDS = 85;
    localparam int                DRAIN_WAIT  = wma_pkg::MAX_WINDOW + 60;

    // Tracks the price history and the queue of averages still owed by the block.
    class average_scoreboard;
        typedef struct {
            wma_pkg::avg_t average;
            wma_pkg::ts_t  stamp;
        } average_t;

        wma_pkg::price_t history[wma_pkg::MAX_WINDOW];
        int              newest;
        wma_pkg::win_t   window_reg;
        average_t        owed_averages[$];
        int              errors;

        function new();
            foreach (history[i]) begin
                history[i] = '0;
            end
            newest     = 0;
            window_reg = wma_pkg::WINDOW_RESET;
            errors     = 0;
        endfunction

        function void set_window(wma_pkg::win_t value);
            window_reg = value;
        endfunction

        function int owed();
            return owed_averages.size();
        endfunction

        function void note_price(wma_pkg::price_t price, wma_pkg::ts_t stamp, bit start);
            int          n;
            int          k;
            int          slot;
            logic [63:0] weighted;
            logic [63:0] weight_total;
            average_t    owed_word;
            n = (window_reg == 0) ? 1 :
                ((window_reg > wma_pkg::MAX_WINDOW) ? wma_pkg::MAX_WINDOW : window_reg);
            if (start) begin
                // a new series floods the whole history with its first price
                foreach (history[i]) begin
                    history[i] = price;
                end
                newest = 0;
            end else begin
                newest = (newest + 1) % wma_pkg::MAX_WINDOW;
                history[newest] = price;
            end
            weighted = '0;
            for (k = 0; k < n; k++) begin
                slot = (newest + wma_pkg::MAX_WINDOW - k) % wma_pkg::MAX_WINDOW;
                weighted += 64'(n - k) * 64'(history[slot]);
            end
            weight_total = 64'(n) * 64'(n + 1) / 64'd2;
            owed_word.average = wma_pkg::avg_t'(weighted / weight_total);
            owed_word.stamp   = stamp;
            owed_averages.insert(owed_averages.size(), owed_word);
        endfunction

        function void check_average(wma_pkg::avg_t average, wma_pkg::ts_t stamp);
            average_t owed_word;
            if (owed_averages.size() == 0) begin
                $display("%0t: unexpected result word, average %h timestamp %h",
                         $time, average, stamp);
                errors++;
                return;
            end
            owed_word = owed_averages.pop_front();
            if (average !== owed_word.average) begin
                $display("%0t: average mismatch, expected %h actual %h",
                         $time, owed_word.average, average);
                errors++;
            end
            if (stamp !== owed_word.stamp) begin
                $display("%0t: timestamp mismatch, expected %h actual %h",
                         $time, owed_word.stamp, stamp);
                errors++;
            end
        endfunction

        function void check_window_readback(logic [wma_pkg::APB_DATA_W-1:0] data);
            if (data !== wma_pkg::APB_DATA_W'(window_reg)) begin
                $display("%0t: window_length readback mismatch, expected %h actual %h",
                         $time, wma_pkg::APB_DATA_W'(window_reg), data);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [wma_pkg::ADDR_W-1:0]     paddr = '0;
    logic [wma_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [wma_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [wma_pkg::DATA_W-1:0]     s_tdata = '0;  // price[31:0], timestamp[94:32], zero[95]
    logic                           s_tuser = 1'b0;  // series_start
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [wma_pkg::DATA_W-1:0]     m_tdata;  // average[31:0], out_timestamp[94:32], zero[95]

    average_scoreboard sb;
    bit                quiet = 1'b0;
    int                cycles = 0;
    int                stall_left = 0;
    wma_pkg::price_t   last_price = '0;

    weighted_moving_average i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: stall in random bursts, never while quiet.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_left > 0 && !quiet) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 17);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_average(m_tdata[wma_pkg::AVG_W-1:0],
                             m_tdata[wma_pkg::AVG_W+wma_pkg::TS_W-1:wma_pkg::AVG_W]);
        end
    end

    task automatic apb_write(input wma_pkg::reg_idx_t idx,
                             input logic [wma_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == wma_pkg::REG_WINDOW_LENGTH) begin
            sb.set_window(wma_pkg::win_t'(data));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read_window();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {wma_pkg::REG_WINDOW_LENGTH, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_window_readback(prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_price(input wma_pkg::price_t price, input wma_pkg::ts_t stamp,
                              input bit start);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, stamp, price};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        sb.note_price(price, stamp, start);
        last_price = price;
    endtask

    // Drop valid and let the block finish every word before touching the register.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random_price(input bit start);
        wma_pkg::price_t price;
        case ($urandom_range(0, 7))
            0: price = '0;
            1: price = '1;
            2, 3: price = wma_pkg::price_t'($urandom);
            4: price = last_price + wma_pkg::price_t'($urandom_range(0, 4095));
            5: price = last_price - wma_pkg::price_t'($urandom_range(0, 4095));
            6: price = wma_pkg::price_t'($urandom_range(0, 65535));
            default: price = '1 - wma_pkg::price_t'($urandom_range(0, 255));
        endcase
        send_price(price, wma_pkg::ts_t'({$urandom, $urandom}), start);
    endtask

    task automatic run_phase(input logic [wma_pkg::APB_DATA_W-1:0] window_value,
                             input int words);
        int i;
        settle();
        apb_write(wma_pkg::REG_WINDOW_LENGTH, window_value);
        apb_read_window();
        // half of the phases keep the old series so the new window meets old history
        send_random_price($urandom_range(0, 1) == 0);
        for (i = 1; i < words; i++) begin
            send_random_price($urandom_range(0, 19) == 0);
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_read_window();

        // no series yet: empty slots count as zero
        send_price('1, '0, 1'b0);
        send_price('0, '1, 1'b0);
        send_price(wma_pkg::price_t'(32'h1234_5678), wma_pkg::ts_t'({$urandom, $urandom}),
                   1'b0);
        // series start echoes the price, later words fill their missing history with it
        send_price('1, '1, 1'b1);
        send_price('1, wma_pkg::ts_t'({$urandom, $urandom}), 1'b0);
        send_price('0, wma_pkg::ts_t'({$urandom, $urandom}), 1'b0);
        send_price(wma_pkg::price_t'(1), wma_pkg::ts_t'({$urandom, $urandom}), 1'b0);
        send_price('0, '0, 1'b1);
        send_price('1, wma_pkg::ts_t'({$urandom, $urandom}), 1'b0);
        send_price(wma_pkg::price_t'(32'h0001_0000), wma_pkg::ts_t'({$urandom, $urandom}),
                   1'b1);
        repeat (5) send_random_price(1'b0);
        send_price('1, wma_pkg::ts_t'({$urandom, $urandom}), 1'b1);
        send_price(wma_pkg::price_t'($urandom), wma_pkg::ts_t'({$urandom, $urandom}), 1'b1);

        run_phase(wma_pkg::APB_DATA_W'(64), PHASE_WORDS);
        run_phase(wma_pkg::APB_DATA_W'(1), PHASE_WORDS);
        // zero is taken as a window of one
        run_phase(wma_pkg::APB_DATA_W'(0), PHASE_WORDS);
        // above the history depth saturates to it
        run_phase(wma_pkg::APB_DATA_W'(127), PHASE_WORDS);
        settle();
        apb_write(REG_SPARE, wma_pkg::APB_DATA_W'($urandom));
        apb_read_window();
        // only the low seven bits are kept
        run_phase(32'hFFFF_FF85, PHASE_WORDS);
        run_phase(wma_pkg::APB_DATA_W'(200), PHASE_WORDS);
        run_phase(wma_pkg::APB_DATA_W'($urandom_range(2, 9)), PHASE_WORDS);
        run_phase(wma_pkg::APB_DATA_W'($urandom_range(2, 63)), PHASE_WORDS);
        run_phase(wma_pkg::APB_DATA_W'($urandom_range(2, 16)), PHASE_WORDS);
        settle();
        quiet = 1'b1;
        run_phase(wma_pkg::APB_DATA_W'($urandom_range(1, 64)), PHASE_WORDS);

        s_tvalid <= 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
